// File: sv/jpp_pkg.sv
// ----------------------------------------------------------------------------
// jpp_pkg: shared types, constants and helpers for the JSON pretty printer
// Character codes, level and count widths, the job word that travels from
// the classifier to the emitter, and small character tests.
// ----------------------------------------------------------------------------
package jpp_pkg;

  // Nesting level saturates here
  localparam int LEVEL_W = 3;
  localparam logic [LEVEL_W-1:0] MAX_DEPTH = 3'd7;

  // Space count of one indent: four per level
  localparam int CNT_W = LEVEL_W + 2;

  // Job queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_ONE     = 8'h31;

  // Work for one input byte, emitted in field order
  typedef struct packed {
    logic             lead;    // space after a colon
    logic             nla;     // newline of the first indent
    logic [CNT_W-1:0] spa;     // spaces of the first indent
    logic             nlb;     // newline of the second indent
    logic [CNT_W-1:0] spb;     // spaces of the second indent
    logic             chr;     // pass the byte itself
    logic [7:0]       ch;
    logic             doc;     // closing bracket at level zero
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic is_open(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_LBRACK);
  endfunction

  function automatic logic is_close(input logic [7:0] c);
    return (c == CH_RBRACE) || (c == CH_RBRACK);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic [CNT_W-1:0] indent_cnt(input logic [LEVEL_W-1:0] lvl);
    return {lvl, 2'b00};
  endfunction

endpackage

// File: sv/jpp_front.sv
// ----------------------------------------------------------------------------
// jpp_front: input classifier
// Takes one byte per cycle while the job queue is not full, tracks string,
// escape and nesting state and turns each byte into a job word for the
// emitter. Bytes that produce nothing update the state and are not queued.
// ----------------------------------------------------------------------------
module jpp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  jpp_pkg::qstat_t     qstat,
  output logic                push,
  output jpp_pkg::job_t       push_job
);

  logic [7:0]                  prev_char, prev_char_next;
  logic                        in_string, in_string_next;
  logic                        in_escape, in_escape_next;
  logic [jpp_pkg::LEVEL_W-1:0] nest_level, nest_level_next;
  logic [jpp_pkg::LEVEL_W-1:0] lvl_mid;
  logic                        accept;
  logic                        skip_doc;
  jpp_pkg::job_t               job;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  // Classify the byte against the state left by the previous one
  always_comb begin
    prev_char_next  = in_byte;
    in_string_next  = in_string;
    in_escape_next  = in_escape;
    nest_level_next = nest_level;
    lvl_mid         = nest_level;
    skip_doc        = 1'b0;
    job             = '0;
    job.ch          = in_byte;

    if (in_string && in_byte == jpp_pkg::CH_BSLASH) begin
      in_escape_next = !in_escape;
      job.chr        = 1'b1;
    end else if (in_escape) begin
      in_escape_next = 1'b0;
      if (in_byte == jpp_pkg::CH_QUOTE) begin
        // escaped quote: quote alone, neutral previous mark
        prev_char_next = jpp_pkg::CH_ONE;
        skip_doc       = 1'b1;
      end
      job.chr = in_string || !jpp_pkg::is_ws(in_byte);
    end else begin
      // string flag flips on the byte after a quote
      in_string_next = in_string ^ (prev_char == jpp_pkg::CH_QUOTE);
      if (!in_string_next) begin
        job.lead = (prev_char == jpp_pkg::CH_COLON);
        if (jpp_pkg::is_open(prev_char)) begin
          if (nest_level < jpp_pkg::MAX_DEPTH) begin
            lvl_mid = nest_level + 1'b1;
          end
          job.nla = 1'b1;
          job.spa = jpp_pkg::indent_cnt(lvl_mid);
        end else if (prev_char == jpp_pkg::CH_COMMA) begin
          job.nla = 1'b1;
          job.spa = jpp_pkg::indent_cnt(nest_level);
        end
        nest_level_next = lvl_mid;
        if (jpp_pkg::is_close(in_byte)) begin
          if (lvl_mid != '0) begin
            nest_level_next = lvl_mid - 1'b1;
          end
          job.nlb = 1'b1;
          job.spb = jpp_pkg::indent_cnt(nest_level_next);
        end else if (jpp_pkg::is_open(in_byte) && prev_char != jpp_pkg::CH_COMMA &&
                     !jpp_pkg::is_open(prev_char)) begin
          job.nlb = 1'b1;
          job.spb = jpp_pkg::indent_cnt(lvl_mid);
        end
      end
      job.chr = in_string_next || !jpp_pkg::is_ws(in_byte);
    end

    job.doc = !skip_doc && (nest_level_next == '0) && jpp_pkg::is_close(in_byte);
  end

  // Only jobs with output go to the queue
  assign push     = accept && (job.lead || job.nla || job.nlb || job.chr);
  assign push_job = job;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_char  <= '0;
      in_string  <= 1'b0;
      in_escape  <= 1'b0;
      nest_level <= '0;
    end else if (accept) begin
      prev_char  <= prev_char_next;
      in_string  <= in_string_next;
      in_escape  <= in_escape_next;
      nest_level <= nest_level_next;
    end
  end

endmodule

// File: sv/jpp_queue.sv
// ----------------------------------------------------------------------------
// jpp_queue: job queue
// Short register queue between classifier and emitter so that either side
// can stall without holding the other.
// ----------------------------------------------------------------------------
module jpp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jpp_pkg::job_t   push_job,
  input  logic            pop,
  output jpp_pkg::job_t   pop_job,
  output jpp_pkg::qstat_t qstat
);

  jpp_pkg::job_t               slots [jpp_pkg::QDEPTH];
  logic [jpp_pkg::QPTR_W-1:0]  wr_ptr;
  logic [jpp_pkg::QPTR_W-1:0]  rd_ptr;
  logic [jpp_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign qstat.full  = (count == jpp_pkg::QCNT_W'(jpp_pkg::QDEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_job     = slots[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == jpp_pkg::QPTR_W'(jpp_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == jpp_pkg::QPTR_W'(jpp_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/jpp_back.sv
// ----------------------------------------------------------------------------
// jpp_back: byte emitter
// Holds one job and plays it out one byte per cycle while the receiver
// keeps up: leading space, first indent, second indent, then the byte
// itself. An output register decouples the emitter from the receiver.
// ----------------------------------------------------------------------------
module jpp_back (
  input  logic            clk,
  input  logic            rst,
  input  jpp_pkg::qstat_t qstat,
  input  jpp_pkg::job_t   pop_job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            run_end,
  output logic            doc_end
);

  jpp_pkg::job_t job, job_next;
  logic          job_valid;
  logic [7:0]    byte_sel;
  logic          last;
  logic          advance;

  assign advance = job_valid && (!out_valid || out_ready);
  assign pop     = !qstat.empty && (!job_valid || (advance && last));

  // Pick the first pending piece of the job
  always_comb begin
    job_next = job;
    byte_sel = jpp_pkg::CH_SPACE;
    if (job.lead) begin
      job_next.lead = 1'b0;
    end else if (job.nla) begin
      byte_sel     = jpp_pkg::CH_LF;
      job_next.nla = 1'b0;
    end else if (job.spa != '0) begin
      job_next.spa = job.spa - 1'b1;
    end else if (job.nlb) begin
      byte_sel     = jpp_pkg::CH_LF;
      job_next.nlb = 1'b0;
    end else if (job.spb != '0) begin
      job_next.spb = job.spb - 1'b1;
    end else begin
      byte_sel     = job.ch;
      job_next.chr = 1'b0;
    end
    last = !(job_next.lead || job_next.nla || (job_next.spa != '0) ||
             job_next.nlb || (job_next.spb != '0) || job_next.chr);
  end

  // Current job
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (pop) begin
      job_valid <= 1'b1;
    end else if (advance && last) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
    end else if (advance) begin
      job <= job_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= byte_sel;
      run_end  <= last;
      doc_end  <= last && job.doc;
    end
  end

endmodule

// File: sv/json_pretty_print_stream_core.sv
// ----------------------------------------------------------------------------
// json_pretty_print_stream_core: streaming JSON reindenter
// Reads JSON text a byte at a time and writes it back reindented.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_byte carries one text byte per word.
// Output channel out_valid/out_ready carries out_byte, with run_end set on
// the last byte produced for an input byte and doc_end set on that byte
// when the input byte is a closing bracket and leaves the level at zero.
// Whitespace outside strings is not passed on but can carry the space or
// indent owed to the byte before it. A classifier takes one input byte per
// cycle and queues a job for each byte with output; the emitter writes one
// byte per cycle while the receiver keeps up, so an input byte producing k
// bytes (up to 55: an indent at full depth, a closing-bracket indent one
// level down, the byte) holds it for all k. Plain characters flow at one
// per cycle when the output accepts; input stalls once the two-entry job
// queue fills behind a long indent. An accepted byte passes the job queue,
// the job register and the output register. Synchronous reset clears the
// string, escape and level state, empties the queue and drops any pending
// output. When out_ready is low the output word holds, the emitter stops,
// and the queue fills until in_ready falls.
// ----------------------------------------------------------------------------
module json_pretty_print_stream_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       doc_end
);

  jpp_pkg::qstat_t qstat;
  jpp_pkg::job_t   push_job;
  jpp_pkg::job_t   pop_job;
  logic            push;
  logic            pop;

  jpp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  jpp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .qstat    (qstat)
  );

  jpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_end   (run_end),
    .doc_end   (doc_end)
  );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for json_pretty_print_stream_core
// Streams directed and random JSON-like text into the reindenter and checks
// every output word against an in-bench model of the reindent rules. Both
// channels idle and stall at random, and the output side holds off for one
// long stretch so that the job queue fills and the input stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jpp_pkg::*;

  localparam int RAND_WORDS = 300;
  localparam int CYC_LIMIT  = 200000;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL_CYC   = 20;

  // One expected output word
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       doc;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_end;
  logic       doc_end;

  logic [7:0] text_q[$];
  out_word_t  pending_out[$];
  int         err_cnt = 0;
  int         cyc = 0;
  int         hold_left = 0;
  logic       held = 1'b0;
  logic       in_acc = 1'b0;

  // Model state
  logic [7:0]         last_ch = 8'h00;
  logic               str_on = 1'b0;
  logic               esc_on = 1'b0;
  logic [LEVEL_W-1:0] lvl = '0;
  int                 n_new;

  json_pretty_print_stream_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .run_end(run_end), .doc_end(doc_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic note_err(input string msg);
    $display("MISMATCH @%0d: %s", cyc, msg);
    err_cnt++;
  endtask

  function automatic logic opener(input logic [7:0] b);
    return b == CH_LBRACE || b == CH_LBRACK;
  endfunction

  function automatic logic closer(input logic [7:0] b);
    return b == CH_RBRACE || b == CH_RBRACK;
  endfunction

  function automatic logic blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  task automatic push_out(input logic [7:0] b);
    pending_out.push_back('{ch: b, last: 1'b0, doc: 1'b0});
    n_new++;
  endtask

  task automatic emit_indent(input logic [LEVEL_W-1:0] l);
    push_out(CH_LF);
    repeat (4 * l) push_out(CH_SPACE);
  endtask

  // Work out the words one input byte produces and queue them
  task automatic reindent_byte(input logic [7:0] b);
    logic esc_quote;
    esc_quote = 1'b0;
    n_new = 0;
    if (str_on && b == CH_BSLASH) begin
      esc_on = !esc_on;
    end else if (esc_on) begin
      esc_on = 1'b0;
      esc_quote = (b == CH_QUOTE);
    end else begin
      // string flag flips one byte late
      if (last_ch == CH_QUOTE) str_on = !str_on;
      if (!str_on) begin
        if (last_ch == CH_COLON) push_out(CH_SPACE);
        if (opener(last_ch)) begin
          if (lvl < MAX_DEPTH) lvl++;
          emit_indent(lvl);
        end else if (last_ch == CH_COMMA) begin
          emit_indent(lvl);
        end
        if (closer(b)) begin
          if (lvl > 0) lvl--;
          emit_indent(lvl);
        end else if (opener(b) && last_ch != CH_COMMA && !opener(last_ch)) begin
          emit_indent(lvl);
        end
      end
    end
    if (esc_quote) begin
      // quote passes once; neutral mark keeps it from toggling the string
      push_out(CH_QUOTE);
      last_ch = CH_ONE;
    end else begin
      last_ch = b;
      if (str_on || !blank(b)) push_out(b);
    end
    if (n_new > 0) begin
      pending_out[$].last = 1'b1;
      // an escaped quote never flags a document end
      if (!esc_quote) pending_out[$].doc = (lvl == 0) && closer(b);
    end
  endtask

  // Sampling at the rising edge: output check, then input acceptance
  always @(posedge clk) begin
    out_word_t w;
    cyc = cyc + 1;
    in_acc = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_out.size() == 0) begin
          note_err($sformatf("unexpected word %h", out_byte));
        end else begin
          w = pending_out.pop_front();
          if (out_byte !== w.ch)
            note_err($sformatf("out_byte %h, want %h", out_byte, w.ch));
          if (run_end !== w.last)
            note_err($sformatf("run_end %b, want %b (byte %h)", run_end, w.last, w.ch));
          if (doc_end !== w.doc)
            note_err($sformatf("doc_end %b, want %b (byte %h)", doc_end, w.doc, w.ch));
        end
      end
      in_acc = in_valid && in_ready;
      if (in_acc) reindent_byte(in_byte);
    end
    if (cyc > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("json_pretty_print_stream_core verification failed");
      $finish;
    end
  end

  // Sender: holds each word until accepted, idles at random outside the quiet window
  always @(negedge clk) begin
    logic quiet;
    quiet = cyc >= 600 && cyc < 1400;
    if (!rst && (!in_valid || in_acc)) begin
      if (text_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 28)) begin
        in_valid <= 1'b1;
        in_byte  <= text_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long output hold-off once the random text is well under way
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!rst && !held && text_q.size() <= 150) begin
      hold_left <= HOLD_LEN;
      held <= 1'b1;
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    logic quiet;
    quiet = cyc >= 600 && cyc < 1400;
    if (rst) out_ready <= 1'b0;
    else out_ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 28);
  end

  task automatic add_text(input logic [7:0] b);
    text_q.push_back(b);
  endtask

  initial begin
    int n_words;
    int depth;
    int pick;
    int len;
    logic [7:0] b;

    // Directed: zero and all-ones bytes, stray closer at level zero,
    // nesting past the depth limit, escapes in a string, dropped blanks
    add_text(8'h00);
    add_text(8'hFF);
    add_text(CH_RBRACE);
    repeat (8) add_text(CH_LBRACK);
    add_text(CH_SPACE);
    add_text(CH_COMMA);
    add_text(CH_QUOTE);
    add_text("a");
    add_text(CH_BSLASH);
    add_text(CH_QUOTE);
    add_text(CH_BSLASH);
    add_text("n");
    add_text(CH_QUOTE);
    add_text(CH_COLON);
    add_text(CH_TAB);
    add_text(CH_CR);
    add_text(CH_LF);
    add_text(CH_RBRACK);

    // Random: mostly JSON-shaped tokens with random content, some noise
    n_words = 0;
    depth = 0;
    while (n_words < RAND_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 16 && depth < 9) begin
        add_text($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK);
        depth++;
        n_words++;
      end else if (pick < 30 && depth > 0) begin
        add_text($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK);
        depth--;
        n_words++;
      end else if (pick < 42) begin
        add_text(CH_COMMA);
        n_words++;
      end else if (pick < 50) begin
        add_text(CH_COLON);
        n_words++;
      end else if (pick < 68) begin
        // string with escaped quotes and backslashes now and then
        add_text(CH_QUOTE);
        len = $urandom_range(0, 6);
        repeat (len) begin
          b = 8'($urandom_range(32, 126));
          if (b == CH_QUOTE || b == CH_BSLASH || $urandom_range(0, 9) == 0) begin
            add_text(CH_BSLASH);
            n_words++;
          end
          add_text(b);
          n_words++;
        end
        add_text(CH_QUOTE);
        n_words += 2;
      end else if (pick < 78) begin
        len = $urandom_range(1, 4);
        repeat (len) add_text(8'($urandom_range(8'h30, 8'h39)));
        n_words += len;
      end else if (pick < 88) begin
        // blanks between tokens: ignored, not counted
        case ($urandom_range(0, 3))
          0: add_text(CH_SPACE);
          1: add_text(CH_TAB);
          2: add_text(CH_CR);
          default: add_text(CH_LF);
        endcase
      end else begin
        b = 8'($urandom_range(0, 255));
        add_text(b);
        if (!blank(b)) n_words++;
      end
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Drain: all text accepted, all words seen, then a short tail
    while (text_q.size() > 0 || in_valid) @(posedge clk);
    while (pending_out.size() > 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("json_pretty_print_stream_core verification clean");
    end else begin
      $display("json_pretty_print_stream_core verification failed");
    end
    $finish;
  end

endmodule

// File: json_pretty_print_stream_core.f
sv/jpp_pkg.sv
sv/jpp_front.sv
sv/jpp_queue.sv
sv/jpp_back.sv
sv/json_pretty_print_stream_core.sv
test/tb.sv
